/* rtl/fet_pkg.sv */
// shared constants and elaboration-time log helpers for the fisher exact test block
package fet_pkg;

  localparam int unsigned CNT_W  = 10;   // width of one input count
  localparam int unsigned N_W    = 12;   // width of a margin total (four counts)
  localparam int unsigned TERM_W = 57;   // series term and sum, Q56 up to 1.0
  localparam int unsigned REM_W  = 61;   // reduced argument x << 32
  localparam int unsigned DIVS_W = 6;    // series index, 1 to 39
  localparam int unsigned KSH_W  = 6;    // ln2 multiple
  localparam int unsigned P_W    = 33;   // p-value Q1.32

  localparam logic [31:0]       EXP_CUTOFF_Q24 = 32'd372456243;
  localparam logic [P_W-1:0]    ONE_Q32        = {1'b1, 32'd0};
  localparam logic [TERM_W-1:0] ONE_Q56        = {1'b1, 56'd0};
  localparam logic [DIVS_W-1:0] LAST_TERM      = 6'd39;
  localparam logic [KSH_W-1:0]  MAX_K          = 6'd32;

  // shift-subtract division, only evaluated at elaboration
  function automatic logic [63:0] fet_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      q = q << 1;
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] fet_mul_shr(input logic [63:0] a, input logic [63:0] b,
                                              input int unsigned s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    return p[63:0];
  endfunction

  // atanh(num/den) in Q62
  function automatic logic [63:0] fet_atanh_q62(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] t2;
    logic [63:0] pw;
    logic [63:0] sum;
    logic [63:0] j;
    r = num;
    q = '0;
    sum = '0;
    for (int i = 0; i < 62; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    t2 = fet_mul_shr(q, q, 62);
    pw = q;
    j = 64'd1;
    while (pw != 0 && j < 64'd400) begin
      sum = sum + fet_udiv(pw, j);
      pw = fet_mul_shr(pw, t2, 62);
      j = j + 64'd2;
    end
    return sum;
  endfunction

  function automatic logic [55:0] fet_ln2_q56();
    logic [63:0] v;
    v = (64'd2 * fet_atanh_q62(64'd1, 64'd3) + 64'd32) >> 6;
    return v[55:0];
  endfunction

  localparam logic [55:0] LN2_Q56 = fet_ln2_q56();

  // ln x in Q40 for x >= 2
  function automatic logic [63:0] fet_ln_q40(input logic [63:0] x);
    int unsigned e;
    logic [63:0] p;
    logic [63:0] lm;
    logic [63:0] lx;
    e = 0;
    while ((x >> (e + 1)) != 0) e++;
    p = 64'd1 << e;
    lm = (x == p) ? 64'd0 : 64'd2 * fet_atanh_q62(x - p, x + p);
    lx = 64'(e) * {8'd0, LN2_Q56} + ((lm + 64'd32) >> 6);
    return (lx + (64'd1 << 15)) >> 16;
  endfunction

endpackage

/* rtl/fet_rom.sv */
// ln(k!) lookup in Q24, contents built at elaboration, registered read
module fet_rom
  import fet_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 37
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  output logic [WIDTH-1:0]         data_o
);

  function automatic logic [DEPTH*WIDTH-1:0] build_rom();
    logic [DEPTH*WIDTH-1:0] bits;
    logic [63:0] acc;
    logic [63:0] ent;
    bits = '0;
    acc = '0;
    for (int unsigned k = 1; k < DEPTH; k++) begin
      if (k >= 2) acc = acc + fet_ln_q40(64'(k));
      ent = (acc + (64'd1 << 15)) >> 16;
      bits[k*WIDTH +: WIDTH] = ent[WIDTH-1:0];
    end
    return bits;
  endfunction

  localparam logic [DEPTH*WIDTH-1:0] ROM_BITS = build_rom();

  always_ff @(posedge clk_i) begin
    data_o <= ROM_BITS[addr_i*WIDTH +: WIDTH];
  end

endmodule

/* rtl/fet_mul.sv */
// 57x57 multiply with result >> 56, four 32x32 partial products accumulated in turn
module fet_mul
  import fet_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TERM_W-1:0] a_i,
  input  logic [TERM_W-1:0] b_i,
  output logic              done_o,
  output logic [TERM_W-1:0] prod_o
);

  localparam int unsigned HI_W  = TERM_W - 32;
  localparam int unsigned ACC_W = 2 * TERM_W;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [TERM_W-1:0] a_q, a_d, b_q, b_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [31:0]       op_a, op_b;
  logic [63:0]       pp;
  logic [ACC_W-1:0]  pp_sh;

  always_comb begin
    op_a = cnt_q[1] ? {{(32-HI_W){1'b0}}, a_q[TERM_W-1:32]} : a_q[31:0];
    op_b = cnt_q[0] ? {{(32-HI_W){1'b0}}, b_q[TERM_W-1:32]} : b_q[31:0];
    pp   = {32'd0, op_a} * {32'd0, op_b};
    unique case (cnt_q)
      2'd0:    pp_sh = ACC_W'(pp);
      2'd3:    pp_sh = ACC_W'(pp) << 64;
      default: pp_sh = ACC_W'(pp) << 32;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 2'd0;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + pp_sh;
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q[56 +: TERM_W];

endmodule

/* rtl/fet_div.sv */
// restoring divider of a series term by its small index, one quotient bit a cycle
module fet_div
  import fet_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TERM_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic              done_o,
  output logic [TERM_W-1:0] quot_o
);

  localparam int unsigned CNT_DW = $clog2(TERM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_DW-1:0] cnt_q, cnt_d;
  logic [DIVS_W-1:0] rem_q, rem_d, dv_q, dv_d;
  logic [TERM_W-1:0] quo_q, quo_d;
  logic [DIVS_W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[TERM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_DW'(TERM_W - 1);
      rem_d  = '0;
      dv_d   = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dv_q}) begin
        rem_d = DIVS_W'(trial - {1'b0, dv_q});
        quo_d = {quo_q[TERM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIVS_W-1:0];
        quo_d = {quo_q[TERM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_DW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dv_q  <= dv_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* rtl/fisher_exact_test_2x2.sv */
// fisher exact test on a 2x2 table: table walk sequencer around shared rom, multiplier and divider
//
//  channel   dir   handshake               payload
//  s_axis    in    tvalid/tready           tdata: count_a, count_b, count_c, count_d
//  m_axis    out   tvalid/tready           tdata: p_value, tuser: range_error
//  apb       in    psel/penable/pready     reg 0 at byte 0: tail_mode
//
//  from the accepting edge an item first takes the nine rom reads of the observed table, then per
//  walked table the nine rom reads, a compare, the ln2 reduction, up to 17 taylor terms (each
//  a start, a multiply and a divide), a round and a step; a table skipped at the compare goes
//  straight to the step. the serial divider sets most of it
//  a range error beat goes straight to the output state. s_axis_tready is high only while idle
//  a finished result waits in the output register; the next beat is taken meanwhile
module fisher_exact_test_2x2
  import fet_pkg::*;
#(
  parameter int unsigned LOG_TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // count_a, count_b, count_c, count_d
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // p_value, zero pad
  output logic        m_axis_tuser,   // range_error
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W = $clog2(LOG_TABLE_DEPTH);
  localparam int unsigned ROM_W = 24 + $clog2((LOG_TABLE_DEPTH * IDX_W * 7) / 10 + 1);
  localparam int unsigned LP_W  = ROM_W + 3;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LP    = 10'b0000000010,
    S_EVAL  = 10'b0000000100,
    S_RED   = 10'b0000001000,
    S_MUL   = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_ROUND = 10'b0001000000,
    S_NEXT  = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_e;

  typedef enum logic [1:0] {
    TAIL_LEFT  = 2'd0,
    TAIL_RIGHT = 2'd1,
    TAIL_TWO   = 2'd2
  } tail_e;

  state_e state_q, state_d;

  logic [1:0]            tail_q;
  logic [N_W-1:0]        a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d, n_q, n_d;
  logic [N_W-1:0]        sa_q, sa_d, sb_q, sb_d, sc_q, sc_d, sd_q, sd_d;
  logic [N_W-1:0]        steps_q, steps_d;
  logic signed [LP_W-1:0] obs_q, obs_d, acc_q, acc_d;
  logic [3:0]            lt_q, lt_d;
  logic                  obsph_q, obsph_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [KSH_W-1:0]      k_q, k_d;
  logic [TERM_W-1:0]     sum_q, sum_d, term_q, term_d;
  logic [DIVS_W-1:0]     i_q, i_d;
  logic [P_W-1:0]        run_q, run_d;
  logic                  err_q, err_d;
  logic                  ov_q, ov_d;
  logic [P_W-1:0]        op_q, op_d;
  logic                  oe_q, oe_d;

  logic [N_W-1:0]        in_a, in_b, in_c, in_d, in_n, mad, mbc;
  logic [N_W-1:0]        ca, cb, cc, cd, idx;
  logic [IDX_W-1:0]      rom_addr;
  logic [ROM_W-1:0]      rom_data;
  logic signed [LP_W-1:0] rom_ext;
  logic [LP_W-1:0]       neg_lp;
  logic                  mul_start, mul_done, div_start, div_done;
  logic [TERM_W-1:0]     mul_prod, div_quot;
  logic [KSH_W-1:0]      shamt;
  logic [TERM_W:0]       rounded;
  logic [P_W:0]          run_sum;
  logic [P_W-1:0]        addend;
  logic                  two_sided;

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {30'd0, tail_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q <= TAIL_TWO;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      tail_q <= pwdata[1:0];
    end
  end

  assign two_sided = tail_q[1];

  assign in_a = N_W'(s_axis_tdata[9:0]);
  assign in_b = N_W'(s_axis_tdata[19:10]);
  assign in_c = N_W'(s_axis_tdata[29:20]);
  assign in_d = N_W'(s_axis_tdata[39:30]);
  assign in_n = in_a + in_b + in_c + in_d;
  assign mad  = (in_a < in_d) ? in_a : in_d;
  assign mbc  = (in_b < in_c) ? in_b : in_c;

  // rom index for the nine log-factorial terms of one table
  always_comb begin
    ca = obsph_q ? a_q : sa_q;
    cb = obsph_q ? b_q : sb_q;
    cc = obsph_q ? c_q : sc_q;
    cd = obsph_q ? d_q : sd_q;
    unique case (lt_q)
      4'd0:    idx = ca + cb;
      4'd1:    idx = cb + cd;
      4'd2:    idx = ca + cc;
      4'd3:    idx = cc + cd;
      4'd4:    idx = n_q;
      4'd5:    idx = ca;
      4'd6:    idx = cb;
      4'd7:    idx = cc;
      default: idx = cd;
    endcase
  end

  assign rom_addr = IDX_W'(idx);

  fet_rom #(
    .DEPTH (LOG_TABLE_DEPTH),
    .WIDTH (ROM_W)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  fet_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (term_q),
    .b_i     (rem_q[TERM_W-1:0]),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  fet_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_prod),
    .divisor_i  (i_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign rom_ext = $signed({3'd0, rom_data});
  assign neg_lp  = LP_W'(-acc_q);
  assign shamt   = KSH_W'(24) + k_q;
  assign rounded = ({1'b0, sum_q} + ((TERM_W+1)'(1) << (shamt - KSH_W'(1)))) >> shamt;

  always_comb begin
    state_d   = state_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; n_d = n_q;
    sa_d = sa_q; sb_d = sb_q; sc_d = sc_q; sd_d = sd_q;
    steps_d   = steps_q;
    obs_d     = obs_q;
    acc_d     = acc_q;
    lt_d      = lt_q;
    obsph_d   = obsph_q;
    rem_d     = rem_q;
    k_d       = k_q;
    sum_d     = sum_q;
    term_d    = term_q;
    i_d       = i_q;
    run_d     = run_q;
    err_d     = err_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    addend    = '0;
    ov_d      = ov_q;
    op_d      = op_q;
    oe_d      = oe_q;

    if (ov_q && m_axis_tready) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          a_d = in_a; b_d = in_b; c_d = in_c; d_d = in_d; n_d = in_n;
          run_d = '0;
          if ({20'd0, in_n} >= 32'(LOG_TABLE_DEPTH)) begin
            err_d   = 1'b1;
            state_d = S_OUT;
          end else begin
            err_d   = 1'b0;
            lt_d    = '0;
            obsph_d = 1'b1;
            acc_d   = '0;
            state_d = S_LP;
            if (tail_q == TAIL_RIGHT) begin
              sa_d = in_a; sb_d = in_b; sc_d = in_c; sd_d = in_d;
              steps_d = mbc;
            end else begin
              sa_d = in_a - mad; sb_d = in_b + mad;
              sc_d = in_c + mad; sd_d = in_d - mad;
              steps_d = two_sided ? mad + mbc : mad;
            end
          end
        end
      end
      S_LP: begin
        // rom data is registered, so it belongs to the address of the previous cycle
        if (lt_q == 4'd0) begin
          acc_d = '0;
        end else if (lt_q <= 4'd4) begin
          acc_d = acc_q + rom_ext;
        end else begin
          acc_d = acc_q - rom_ext;
        end
        lt_d = lt_q + 4'd1;
        if (lt_q == 4'd9) begin
          lt_d = '0;
          if (obsph_q) begin
            obs_d   = acc_d;
            obsph_d = 1'b0;
          end else begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (two_sided && (acc_q > obs_q)) begin
          state_d = S_NEXT;
        end else if (!acc_q[LP_W-1]) begin
          addend  = ONE_Q32;
          state_d = S_NEXT;
        end else if (neg_lp > LP_W'(EXP_CUTOFF_Q24)) begin
          state_d = S_NEXT;
        end else begin
          rem_d   = REM_W'(neg_lp) << 32;
          k_d     = '0;
          state_d = S_RED;
        end
      end
      S_RED: begin
        if (rem_q >= REM_W'(LN2_Q56)) begin
          rem_d = rem_q - REM_W'(LN2_Q56);
          k_d   = k_q + KSH_W'(1);
        end else if (k_q > MAX_K) begin
          state_d = S_NEXT;
        end else begin
          sum_d     = ONE_Q56;
          term_d    = ONE_Q56;
          i_d       = DIVS_W'(1);
          state_d   = S_WAIT;
        end
      end
      S_WAIT: begin
        mul_start = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (div_quot == '0) begin
            state_d = S_ROUND;
          end else begin
            sum_d  = i_q[0] ? sum_q - div_quot : sum_q + div_quot;
            term_d = div_quot;
            if (i_q == LAST_TERM) begin
              state_d = S_ROUND;
            end else begin
              i_d     = i_q + DIVS_W'(1);
              state_d = S_WAIT;
            end
          end
        end
      end
      S_ROUND: begin
        addend  = P_W'(rounded);
        state_d = S_NEXT;
      end
      S_NEXT: begin
        if (steps_q == '0) begin
          state_d = S_OUT;
        end else begin
          steps_d = steps_q - N_W'(1);
          sa_d = sa_q + N_W'(1); sd_d = sd_q + N_W'(1);
          sb_d = sb_q - N_W'(1); sc_d = sc_q - N_W'(1);
          lt_d    = '0;
          state_d = S_LP;
        end
      end
      S_OUT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          op_d    = run_q;
          oe_d    = err_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // saturating accumulation of kept probabilities
    run_sum = {1'b0, run_q} + {1'b0, addend};
    if (addend != '0) run_d = (run_sum > {1'b0, ONE_Q32}) ? ONE_Q32 : run_sum[P_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lt_q    <= '0;
      obsph_q <= 1'b0;
      steps_q <= '0;
      k_q     <= '0;
      i_q     <= DIVS_W'(1);
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      lt_q    <= lt_d;
      obsph_q <= obsph_d;
      steps_q <= steps_d;
      k_q     <= k_d;
      i_q     <= i_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; n_q <= n_d;
    sa_q <= sa_d; sb_q <= sb_d; sc_q <= sc_d; sd_q <= sd_d;
    obs_q  <= obs_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    sum_q  <= sum_d;
    term_q <= term_d;
    run_q  <= run_d;
    err_q  <= err_d;
    op_q   <= op_d;
    oe_q   <= oe_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, op_q};
  assign m_axis_tuser  = oe_q;

endmodule

/* rtl/fet_checker.sv */
// port-level checks for the fisher exact test block, bound to the top level
module fet_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        pready
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // one item at a time: busy right after a beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // range error gives a zero p-value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 40'd0)
    else $error("range error with nonzero p-value");

  // p-value saturates at 1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata <= 40'h0100000000)
    else $error("p-value above 1.0");

  assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind fisher_exact_test_2x2 fet_checker u_fet_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .pready        (pready)
);

/* verif/tb_fisher_exact_test_2x2.sv */
// testbench for the 2x2 fisher exact test block: directed tables, then random tables per tail mode
module tb_fisher_exact_test_2x2;
  timeunit 1ns;
  timeprecision 1ps;
  import fet_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam logic [2:0] ADDR_TAIL = 3'd0;
  localparam logic [2:0] ADDR_NONE = 3'd4;

  typedef enum logic [1:0] {
    TAIL_LEFT = 2'd0, TAIL_RIGHT = 2'd1, TAIL_BOTH = 2'd2, TAIL_SPARE = 2'd3
  } tail_e;

  typedef struct packed {
    logic [P_W-1:0] p_value;
    logic           range_error;
  } pval_t;

  typedef struct {
    logic [CNT_W-1:0] a, b, c, d;
    bit               typed;
    pval_t            res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // count_a, count_b, count_c, count_d
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // p_value, zero pad
  logic        m_axis_tuser;        // range_error
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fisher_exact_test_2x2 i_dut (.*);

  always #6 clk_i = ~clk_i;

  longint unsigned lnfact[DEPTH];
  longint unsigned ln2_fix;
  tail_e           tail_cfg;
  pval_t           pending_pvals[$];
  int              errors = 0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;

  function automatic longint unsigned mul_hi(longint unsigned x, longint unsigned y, int s);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    p = p >> s;
    return p[63:0];
  endfunction

  function automatic longint unsigned atanh_fix(longint unsigned num, longint unsigned den);
    longint unsigned r, q, t2, pw, acc, j;
    r = num;
    q = 0;
    acc = 0;
    for (int i = 0; i < 62; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    t2 = mul_hi(q, q, 62);
    pw = q;
    for (j = 1; pw != 0 && j < 400; j += 2) begin
      acc += pw / j;
      pw = mul_hi(pw, t2, 62);
    end
    return acc;
  endfunction

  function automatic longint unsigned ln_q40_of(longint unsigned x);
    int unsigned e;
    longint unsigned p, lm, lx;
    e = 0;
    while ((x >> (e + 1)) != 0) e++;
    p = 64'd1 << e;
    lm = (x == p) ? 0 : 2 * atanh_fix(x - p, x + p);
    lx = longint'(e) * ln2_fix + ((lm + 32) >> 6);
    return (lx + (64'd1 << 15)) >> 16;
  endfunction

  task automatic build_lnfact();
    longint unsigned acc;
    acc = 0;
    ln2_fix = (2 * atanh_fix(1, 3) + 32) >> 6;
    lnfact[0] = 0;
    for (int k = 1; k < DEPTH; k++) begin
      if (k >= 2) acc += ln_q40_of(k);
      lnfact[k] = (acc + (64'd1 << 15)) >> 16;
    end
  endtask

  function automatic longint hyper_log(int a, int b, int c, int d, int n);
    longint unsigned num, den;
    num = lnfact[a+b] + lnfact[b+d] + lnfact[a+c] + lnfact[c+d];
    den = lnfact[n] + lnfact[a] + lnfact[b] + lnfact[c] + lnfact[d];
    return longint'(num) - longint'(den);
  endfunction

  function automatic longint unsigned exp_q32_of(longint lp);
    longint unsigned x, x56, k, r, term, acc;
    int sh;
    if (lp >= 0) return 64'd1 << 32;
    x = -lp;
    if (x > EXP_CUTOFF_Q24) return 0;
    x56 = x << 32;
    k = x56 / ln2_fix;
    if (k > 32) return 0;
    r = x56 - k * ln2_fix;
    acc = 64'd1 << 56;
    term = acc;
    for (int i = 1; i < 40; i++) begin
      term = mul_hi(term, r, 56) / i;
      if (term == 0) break;
      if (i % 2 == 1) acc -= term;
      else acc += term;
    end
    sh = 24 + int'(k);
    return (acc + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic pval_t fisher_p(logic [39:0] cells);
    int a, b, c, d, n, sa, sb, sc, sd, mad, mbc, steps;
    bit both;
    longint obs, lp;
    longint unsigned acc;
    pval_t res;
    a = cells[9:0];
    b = cells[19:10];
    c = cells[29:20];
    d = cells[39:30];
    n = a + b + c + d;
    both = tail_cfg[1];
    if (n >= DEPTH) begin
      res.p_value = '0;
      res.range_error = 1'b1;
      return res;
    end
    mad = a < d ? a : d;
    mbc = b < c ? b : c;
    if (tail_cfg == TAIL_RIGHT) begin
      sa = a; sb = b; sc = c; sd = d;
      steps = mbc;
    end else begin
      sa = a - mad; sb = b + mad; sc = c + mad; sd = d - mad;
      steps = both ? mad + mbc : mad;
    end
    obs = hyper_log(a, b, c, d, n);
    acc = 0;
    forever begin
      lp = hyper_log(sa, sb, sc, sd, n);
      if (!both || lp <= obs) begin
        acc += exp_q32_of(lp);
        if (acc > (64'd1 << 32)) acc = 64'd1 << 32;
      end
      if (steps == 0) break;
      steps--;
      sa++; sd++; sb--; sc--;
    end
    res.p_value = acc[P_W-1:0];
    res.range_error = 1'b0;
    return res;
  endfunction

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_TAIL) tail_cfg = tail_e'(data[1:0]);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic send_table(logic [39:0] cells, bit typed, pval_t res);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tdata = cells;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pvals.push_back(typed ? res : fisher_p(cells));
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (pending_pvals.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // mostly short walks: one cell of each diagonal pair stays small
  function automatic logic [39:0] random_table();
    logic [CNT_W-1:0] a, b, c, d, lo, hi;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      lo = CNT_W'($urandom_range(3)); hi = CNT_W'($urandom_range(255));
      if ($urandom_range(1)) begin a = lo; d = hi; end else begin a = hi; d = lo; end
      lo = CNT_W'($urandom_range(3)); hi = CNT_W'($urandom_range(255));
      if ($urandom_range(1)) begin b = lo; c = hi; end else begin b = hi; c = lo; end
    end else if (pick < 85) begin
      a = CNT_W'($urandom_range(1023));
      c = CNT_W'($urandom_range(1023 - a));
      b = 0; d = 0;
      if ($urandom_range(1)) begin b = a; a = 0; d = c; c = 0; end
    end else begin
      // far outside the log table
      do begin
        a = CNT_W'($urandom); b = CNT_W'($urandom);
        c = CNT_W'($urandom); d = CNT_W'($urandom);
      end while (int'(a) + b + c + d < DEPTH);
    end
    return {d, c, b, a};
  endfunction

  always @(negedge clk_i) m_axis_tready = ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_pvals.size() == 0) begin
        $error("result beat with no table pending");
        errors++;
      end else begin
        pval_t want;
        want = pending_pvals.pop_front();
        if (m_axis_tdata[P_W-1:0] !== want.p_value) begin
          $error("p_value expected %0d actual %0d", want.p_value, m_axis_tdata[P_W-1:0]);
          errors++;
        end
        if (m_axis_tuser !== want.range_error) begin
          $error("range_error expected %0d actual %0d", want.range_error, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  row_t directed[] = '{
    '{10'd0,    10'd0,    10'd0,    10'd0,    1'b1, '{ONE_Q32, 1'b0}},
    '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1, '{'0, 1'b1}},
    '{10'd1023, 10'd0,    10'd0,    10'd0,    1'b1, '{ONE_Q32, 1'b0}},
    '{10'd0,    10'd1023, 10'd0,    10'd0,    1'b1, '{ONE_Q32, 1'b0}},
    '{10'd0,    10'd0,    10'd1023, 10'd0,    1'b1, '{ONE_Q32, 1'b0}},
    '{10'd0,    10'd0,    10'd0,    10'd1023, 1'b1, '{ONE_Q32, 1'b0}},
    '{10'd1023, 10'd1,    10'd0,    10'd0,    1'b1, '{'0, 1'b1}},
    '{10'd512,  10'd0,    10'd511,  10'd0,    1'b1, '{ONE_Q32, 1'b0}},
    '{10'd0,    10'd0,    10'd0,    10'd1023, 1'b1, '{ONE_Q32, 1'b0}},
    '{10'd1,    10'd0,    10'd0,    10'd1,    1'b0, '{'0, 1'b0}},
    '{10'd5,    10'd3,    10'd2,    10'd7,    1'b0, '{'0, 1'b0}},
    '{10'd3,    10'd0,    10'd0,    10'd3,    1'b0, '{'0, 1'b0}},
    '{10'd0,    10'd4,    10'd4,    10'd0,    1'b0, '{'0, 1'b0}},
    '{10'd2,    10'd300,  10'd1,    10'd500,  1'b0, '{'0, 1'b0}},
    '{10'd700,  10'd2,    10'd3,    10'd1,    1'b0, '{'0, 1'b0}},
    '{10'd1,    10'd1,    10'd1,    10'd1,    1'b0, '{'0, 1'b0}},
    '{10'd0,    10'd3,    10'd200,  10'd255,  1'b0, '{'0, 1'b0}},
    '{10'd340,  10'd341,  10'd342,  10'd1,    1'b1, '{'0, 1'b1}}
  };

  initial begin
    tail_e modes[5];
    int    send_pct[5], recv_pct[5];
    modes = '{TAIL_LEFT, TAIL_RIGHT, TAIL_SPARE, TAIL_BOTH, TAIL_LEFT};
    send_pct = '{0, 56, 0, 31, 56};
    recv_pct = '{0, 0, 56, 31, 56};
    build_lnfact();
    tail_cfg = TAIL_BOTH;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i])
      send_table({directed[i].d, directed[i].c, directed[i].b, directed[i].a},
                 directed[i].typed, directed[i].res);
    drain();
    // unmapped address must leave the tail mode alone
    apb_write(ADDR_NONE, 32'd1);
    send_table({10'd2, 10'd1, 10'd3, 10'd2}, 1'b0, '{'0, 1'b0});

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      send_idle_pct = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      // upper bits set to show the value is masked
      apb_write(ADDR_TAIL, {30'h3fff_ffff, modes[ph]});
      for (int k = 0; k < 26; k++) begin
        if (ph == 2 && k == 13) drain();
        send_table(random_table(), 1'b0, '{'0, 1'b0});
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("** fisher_exact_test_2x2: PASSED **");
    else $display("** fisher_exact_test_2x2: FAILED **");
    $finish;
  end

  initial begin
    #300ms;
    $display("** fisher_exact_test_2x2: FAILED **");
    $finish;
  end

endmodule
